// ===== rtl/register_descriptor_allocator_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Register descriptor allocator assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef REGISTER_DESCRIPTOR_ALLOCATOR_UNIT_DEFINES_SVH
`define REGISTER_DESCRIPTOR_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RDA_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("rda assertion failed");

// Next-cycle implication, disabled during reset
`define RDA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("rda assertion failed");

`endif

// ===== rtl/rda_pkg.sv =====
// ---------------------------------------------------------------------------
// Register descriptor allocator package
// Widths, request and result codes, and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rda_pkg;

  localparam int MAX_REGS = 8;
  localparam int REG_W    = 3;   // register index width
  localparam int CNT_W    = 4;   // register count width, holds MAX_REGS
  localparam int VALUE_W  = 16;
  localparam int REQ_W    = 2;
  localparam int KIND_W   = 2;

  localparam logic [CNT_W-1:0] REGS_RESET = CNT_W'(5);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_GRANT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic mark;
    logic emit_grant;
    logic emit_store_victim;
    logic emit_store_scan;
    logic emit_done;
    logic scan_clear;
    logic scan_step;
  } rda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic need_wb;
    logic scan_end;
    logic scan_wb;
  } rda_sts_t;

endpackage

// ===== rtl/rda_datapath.sv =====
// ---------------------------------------------------------------------------
// Register descriptor allocator datapath
// Descriptor table, tag match, free/victim selection, flush scan counter,
// and the result word register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rda_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rda_pkg::CNT_W-1:0]     cfg_data,
  input  logic [rda_pkg::VALUE_W-1:0]   value_id,
  input  logic                          value_is_temp,
  input  logic [rda_pkg::REG_W-1:0]     reg_index,
  input  rda_pkg::rda_cmd_t             cmd,
  output rda_pkg::rda_sts_t             sts,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [rda_pkg::KIND_W-1:0]    out_kind,
  output logic [rda_pkg::REG_W-1:0]     out_reg,
  output logic [rda_pkg::VALUE_W-1:0]   out_value,
  output logic                          hit,
  output logic                          last
);

  // Configuration and table state
  logic [rda_pkg::CNT_W-1:0]   regs_in_use;
  logic [rda_pkg::VALUE_W-1:0] reg_tag [rda_pkg::MAX_REGS];
  logic [rda_pkg::MAX_REGS-1:0] reg_busy;
  logic [rda_pkg::MAX_REGS-1:0] reg_dirty;
  logic [rda_pkg::MAX_REGS-1:0] reg_temp;

  // Held request word
  logic [rda_pkg::VALUE_W-1:0] item_value;
  logic                        item_temp;
  logic [rda_pkg::REG_W-1:0]   item_reg;

  logic [rda_pkg::CNT_W-1:0]   scan_cnt;
  logic [rda_pkg::REG_W-1:0]   scan_idx;

  logic [rda_pkg::CNT_W-1:0]    live_n;
  logic [rda_pkg::MAX_REGS-1:0] in_range;
  logic [rda_pkg::MAX_REGS-1:0] hit_vec;
  logic [rda_pkg::MAX_REGS-1:0] free_vec;
  logic [rda_pkg::MAX_REGS-1:0] clean_vec;
  logic [rda_pkg::REG_W-1:0]    hit_idx;
  logic [rda_pkg::REG_W-1:0]    free_idx;
  logic [rda_pkg::REG_W-1:0]    victim_idx;
  logic [rda_pkg::REG_W-1:0]    grant_idx;
  logic [rda_pkg::REG_W-1:0]    rd_idx;
  logic [rda_pkg::VALUE_W-1:0]  rd_tag;
  logic                         hit_any;
  logic                         free_any;
  logic                         emit_any;
  logic                         mark_ok;

  // Clamp the register count to 1 .. MAX_REGS
  always_comb begin
    if (regs_in_use == '0) begin
      live_n = rda_pkg::CNT_W'(1);
    end else if (regs_in_use > rda_pkg::CNT_W'(rda_pkg::MAX_REGS)) begin
      live_n = rda_pkg::CNT_W'(rda_pkg::MAX_REGS);
    end else begin
      live_n = regs_in_use;
    end
  end

  // Parallel tag match and per-entry qualifiers
  always_comb begin
    for (int i = 0; i < rda_pkg::MAX_REGS; i++) begin
      in_range[i]  = rda_pkg::CNT_W'(i) < live_n;
      hit_vec[i]   = in_range[i] && reg_busy[i] && (reg_tag[i] == item_value);
      free_vec[i]  = in_range[i] && !reg_busy[i];
      clean_vec[i] = in_range[i] && !reg_dirty[i];
    end
  end

  // Lowest-index pick for hit, free and clean; victim falls back to entry 0
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = rda_pkg::MAX_REGS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = rda_pkg::REG_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = rda_pkg::REG_W'(i);
      end
      if (clean_vec[i]) begin
        victim_idx = rda_pkg::REG_W'(i);
      end
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;

  always_comb begin
    if (hit_any) begin
      grant_idx = hit_idx;
    end else if (free_any) begin
      grant_idx = free_idx;
    end else begin
      grant_idx = victim_idx;
    end
  end

  // Single tag read port shared by victim writeback and flush scan
  assign scan_idx = scan_cnt[rda_pkg::REG_W-1:0];
  assign rd_idx   = cmd.emit_store_scan ? scan_idx : victim_idx;
  assign rd_tag   = reg_tag[rd_idx];

  assign mark_ok = (rda_pkg::CNT_W'(item_reg) < live_n) && reg_busy[item_reg];

  // Status back to the controller
  assign emit_any      = cmd.emit_grant | cmd.emit_store_victim |
                         cmd.emit_store_scan | cmd.emit_done;
  assign sts.slot_free = !res_valid || !res_stall;
  assign sts.need_wb   = !hit_any && !free_any &&
                         reg_dirty[victim_idx] && !reg_temp[victim_idx];
  assign sts.scan_end  = scan_cnt >= live_n;
  assign sts.scan_wb   = reg_busy[scan_idx] && reg_dirty[scan_idx] && !reg_temp[scan_idx];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs_in_use <= rda_pkg::REGS_RESET;
    end else if (cfg_write) begin
      regs_in_use <= cfg_data;
    end
  end

  // Hold the accepted request word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_value <= value_id;
      item_temp  <= value_is_temp;
      item_reg   <= reg_index;
    end
  end

  // Flush scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (cmd.scan_clear) begin
      scan_cnt <= '0;
    end else if (cmd.scan_step) begin
      scan_cnt <= scan_cnt + rda_pkg::CNT_W'(1);
    end
  end

  // Tag store: written on a claim, no reset
  always_ff @(posedge clk) begin
    if (cmd.emit_grant && !hit_any) begin
      reg_tag[grant_idx] <= item_value;
    end
  end

  // Busy, dirty and temp flags
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_busy  <= '0;
      reg_dirty <= '0;
      reg_temp  <= '0;
    end else if (cmd.emit_done) begin
      reg_busy  <= '0;
      reg_dirty <= '0;
      reg_temp  <= '0;
    end else if (cmd.emit_grant && !hit_any) begin
      reg_busy[grant_idx]  <= 1'b1;
      reg_dirty[grant_idx] <= 1'b0;
      reg_temp[grant_idx]  <= item_temp;
    end else if (cmd.mark && mark_ok) begin
      reg_dirty[item_reg] <= 1'b1;
    end
  end

  // Result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_any) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result word payload
  always_ff @(posedge clk) begin
    if (cmd.emit_grant) begin
      out_kind  <= rda_pkg::KIND_GRANT;
      out_reg   <= grant_idx;
      out_value <= item_value;
      hit       <= hit_any;
      last      <= 1'b1;
    end else if (cmd.emit_store_victim) begin
      out_kind  <= rda_pkg::KIND_STORE;
      out_reg   <= victim_idx;
      out_value <= rd_tag;
      hit       <= 1'b0;
      last      <= 1'b0;
    end else if (cmd.emit_store_scan) begin
      out_kind  <= rda_pkg::KIND_STORE;
      out_reg   <= scan_idx;
      out_value <= rd_tag;
      hit       <= 1'b0;
      last      <= 1'b0;
    end else if (cmd.emit_done) begin
      out_kind  <= rda_pkg::KIND_DONE;
      out_reg   <= '0;
      out_value <= '0;
      hit       <= 1'b0;
      last      <= 1'b1;
    end
  end

endmodule

// ===== rtl/rda_ctrl.sv =====
// ---------------------------------------------------------------------------
// Register descriptor allocator controller
// Request sequencer: accepts a word, then steps allocate, mark and flush.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rda_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [rda_pkg::REQ_W-1:0]  req_type,
  input  rda_pkg::rda_sts_t          sts,
  output rda_pkg::rda_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_GRANT = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          case (req_type)
            rda_pkg::REQ_ALLOC: state_next = S_ALLOC;
            rda_pkg::REQ_MARK:  state_next = S_MARK;
            rda_pkg::REQ_FLUSH: begin
              cmd.scan_clear = 1'b1;
              state_next     = S_FLUSH;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (sts.slot_free) begin
          if (sts.need_wb) begin
            cmd.emit_store_victim = 1'b1;
            state_next            = S_GRANT;
          end else begin
            cmd.emit_grant = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end
      S_GRANT: begin
        if (sts.slot_free) begin
          cmd.emit_grant = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = S_IDLE;
      end
      S_FLUSH: begin
        if (sts.scan_end) begin
          if (sts.slot_free) begin
            cmd.emit_done = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (sts.scan_wb) begin
          if (sts.slot_free) begin
            cmd.emit_store_scan = 1'b1;
            cmd.scan_step       = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/register_descriptor_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// Register descriptor allocator unit
// Top level: fully associative value-to-register table with writeback.
// ---------------------------------------------------------------------------
// One request word is taken at a time; req_stall stays high until its last
// result word is loaded into the output register. An allocate steps through
// accept, then the parallel tag match and free/victim pick, with the writeback
// of a dirty, non-temp victim first where needed. A mark is accepted, then
// applied. A flush visits the registers in use with the scan counter, one
// table entry per cycle except where a writeback waits on the output register,
// then emits the done word. Result stalls hold the sequence.
`timescale 1ns / 1ps
`include "register_descriptor_allocator_unit_defines.svh"

module register_descriptor_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rda_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [rda_pkg::REQ_W-1:0]     req_type,
  input  logic [rda_pkg::VALUE_W-1:0]   value_id,
  input  logic                          value_is_temp,
  input  logic [rda_pkg::REG_W-1:0]     reg_index,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [rda_pkg::KIND_W-1:0]    out_kind,
  output logic [rda_pkg::REG_W-1:0]     out_reg,
  output logic [rda_pkg::VALUE_W-1:0]   out_value,
  output logic                          hit,
  output logic                          last
);

  rda_pkg::rda_cmd_t cmd;
  rda_pkg::rda_sts_t sts;
  logic              emit_any;
  logic [3:0]        emit_vec;
  logic              req_taken;

  // Sequencer
  rda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table and result register
  rda_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .value_id      (value_id),
    .value_is_temp (value_is_temp),
    .reg_index     (reg_index),
    .cmd           (cmd),
    .sts           (sts),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .out_kind      (out_kind),
    .out_reg       (out_reg),
    .out_value     (out_value),
    .hit           (hit),
    .last          (last)
  );

  assign emit_vec  = {cmd.emit_grant, cmd.emit_store_victim,
                      cmd.emit_store_scan, cmd.emit_done};
  assign emit_any  = |emit_vec;
  assign req_taken = req_valid && !req_stall &&
                     (req_type inside {rda_pkg::REQ_ALLOC, rda_pkg::REQ_MARK,
                                       rda_pkg::REQ_FLUSH});

  // Checks on sequencer and datapath cooperation
  `RDA_ASSERT_IMPLY(a_one_emit, clk, rst, 1'b1, $onehot0(emit_vec))
  `RDA_ASSERT_IMPLY(a_emit_slot, clk, rst, emit_any, sts.slot_free)
  `RDA_ASSERT_IMPLY(a_victim_wb, clk, rst, cmd.emit_store_victim, sts.need_wb)
  `RDA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_taken, req_stall)

endmodule

// ===== dv/rda_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Register descriptor allocator checker
// Watches the request, result and register ports, keeps its own copy of the
// value-to-register table, predicts every result word and compares it.
// ---------------------------------------------------------------------------

module rda_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rda_pkg::CNT_W-1:0]   cfg_data,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic [rda_pkg::REQ_W-1:0]   req_type,
  input  logic [rda_pkg::VALUE_W-1:0] value_id,
  input  logic                        value_is_temp,
  input  logic [rda_pkg::REG_W-1:0]   reg_index,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  logic [rda_pkg::KIND_W-1:0]  out_kind,
  input  logic [rda_pkg::REG_W-1:0]   out_reg,
  input  logic [rda_pkg::VALUE_W-1:0] out_value,
  input  logic                        hit,
  input  logic                        last,
  output int                          mismatch_count,
  output int                          owed_count
);

  typedef struct packed {
    logic [rda_pkg::KIND_W-1:0]  kind;
    logic [rda_pkg::REG_W-1:0]   rg;
    logic [rda_pkg::VALUE_W-1:0] value;
    logic                        hit;
    logic                        last;
  } result_word_t;

  // Shadow of the allocation table
  logic [rda_pkg::VALUE_W-1:0]  tag_q [rda_pkg::MAX_REGS];
  logic [rda_pkg::MAX_REGS-1:0] busy_q;
  logic [rda_pkg::MAX_REGS-1:0] dirty_q;
  logic [rda_pkg::MAX_REGS-1:0] temp_q;
  logic [rda_pkg::CNT_W-1:0]    regs_q;

  result_word_t owed_words [$];

  initial begin
    mismatch_count = 0;
    owed_count     = 0;
  end

  // Clamp the programmed count to 1 .. MAX_REGS
  function automatic int live_regs();
    if (regs_q == 0) return 1;
    if (regs_q > rda_pkg::MAX_REGS) return rda_pkg::MAX_REGS;
    return int'(regs_q);
  endfunction

  task automatic owe_word(input logic [rda_pkg::KIND_W-1:0] kind, input int rg,
                          input logic [rda_pkg::VALUE_W-1:0] value, input logic h,
                          input logic l);
    result_word_t w;
    w.kind  = kind;
    w.rg    = rda_pkg::REG_W'(rg);
    w.value = value;
    w.hit   = h;
    w.last  = l;
    owed_words.push_back(w);
  endtask

  task automatic claim_reg(input int r, input logic [rda_pkg::VALUE_W-1:0] v,
                           input logic t);
    busy_q[r]  = 1'b1;
    tag_q[r]   = v;
    temp_q[r]  = t;
    dirty_q[r] = 1'b0;
  endtask

  // Apply one request word to the table and queue the words it produces
  task automatic resolve_request(input logic [rda_pkg::REQ_W-1:0] rt,
                                 input logic [rda_pkg::VALUE_W-1:0] v,
                                 input logic t, input logic [rda_pkg::REG_W-1:0] ri);
    int n;
    int i;
    int victim;
    n = live_regs();
    victim = 0;
    case (rt)
      rda_pkg::REQ_ALLOC: begin
        for (i = 0; i < n; i++) begin
          if (busy_q[i] && tag_q[i] == v) begin
            owe_word(rda_pkg::KIND_GRANT, i, v, 1'b1, 1'b1);
            return;
          end
        end
        for (i = 0; i < n; i++) begin
          if (!busy_q[i]) begin
            claim_reg(i, v, t);
            owe_word(rda_pkg::KIND_GRANT, i, v, 1'b0, 1'b1);
            return;
          end
        end
        // Table full: lowest clean register, else register 0
        for (i = 0; i < n; i++) begin
          if (!dirty_q[i]) begin
            victim = i;
            break;
          end
        end
        if (dirty_q[victim] && !temp_q[victim])
          owe_word(rda_pkg::KIND_STORE, victim, tag_q[victim], 1'b0, 1'b0);
        claim_reg(victim, v, t);
        owe_word(rda_pkg::KIND_GRANT, victim, v, 1'b0, 1'b1);
      end
      rda_pkg::REQ_MARK: begin
        if (int'(ri) < n && busy_q[ri]) dirty_q[ri] = 1'b1;
      end
      rda_pkg::REQ_FLUSH: begin
        for (i = 0; i < n; i++) begin
          if (busy_q[i] && dirty_q[i] && !temp_q[i])
            owe_word(rda_pkg::KIND_STORE, i, tag_q[i], 1'b0, 1'b0);
        end
        busy_q  = '0;
        dirty_q = '0;
        temp_q  = '0;
        owe_word(rda_pkg::KIND_DONE, 0, '0, 1'b0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Check result words first, then track the register and new requests
  always @(posedge clk) begin : watch
    result_word_t want;
    if (rst) begin
      busy_q  = '0;
      dirty_q = '0;
      temp_q  = '0;
      regs_q  = rda_pkg::REGS_RESET;
      owed_words.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (owed_words.size() == 0) begin
          $error("unexpected result word: kind %0d reg %0d value %0d", out_kind, out_reg,
                 out_value);
          mismatch_count++;
        end else begin
          want = owed_words.pop_front();
          compare_field("out_kind", want.kind, out_kind);
          compare_field("out_reg", want.rg, out_reg);
          compare_field("out_value", want.value, out_value);
          compare_field("hit", want.hit, hit);
          compare_field("last", want.last, last);
        end
      end
      if (cfg_write) regs_q = cfg_data;
      if (req_valid && !req_stall)
        resolve_request(req_type, value_id, value_is_temp, reg_index);
    end
    owed_count = owed_words.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Register descriptor allocator testbench
// Drives directed and random request words through several register counts
// and idle/stall patterns; the checker predicts and compares every result.
// ---------------------------------------------------------------------------

module tb_top;

  localparam logic [rda_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 120;
  localparam int PHASE_WORDS    = 58;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [rda_pkg::CNT_W-1:0]   cfg_data = '0;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  logic [rda_pkg::REQ_W-1:0]   req_type = '0;
  logic [rda_pkg::VALUE_W-1:0] value_id = '0;
  logic                        value_is_temp = 1'b0;
  logic [rda_pkg::REG_W-1:0]   reg_index = '0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  logic [rda_pkg::KIND_W-1:0]  out_kind;
  logic [rda_pkg::REG_W-1:0]   out_reg;
  logic [rda_pkg::VALUE_W-1:0] out_value;
  logic                        hit;
  logic                        last;

  int mismatch_count;
  int owed_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int live = 5;
  logic hold_off = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  register_descriptor_allocator_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .value_id      (value_id),
    .value_is_temp (value_is_temp),
    .reg_index     (reg_index),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .out_kind      (out_kind),
    .out_reg       (out_reg),
    .out_value     (out_value),
    .hit           (hit),
    .last          (last)
  );

  rda_checker u_rda_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .value_id       (value_id),
    .value_is_temp  (value_is_temp),
    .reg_index      (reg_index),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .out_kind       (out_kind),
    .out_reg        (out_reg),
    .out_value      (out_value),
    .hit            (hit),
    .last           (last),
    .mismatch_count (mismatch_count),
    .owed_count     (owed_count)
  );

  // Result side: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word, idling first at random, and hold it until taken
  task automatic send_word(input logic [rda_pkg::REQ_W-1:0] rt,
                           input logic [rda_pkg::VALUE_W-1:0] v,
                           input logic t, input logic [rda_pkg::REG_W-1:0] ri);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    req_type      <= rt;
    value_id      <= v;
    value_is_temp <= t;
    reg_index     <= ri;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid, wait for every owed result word, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (owed_count != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [rda_pkg::CNT_W-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    live = (v == 0) ? 1 : (v > rda_pkg::MAX_REGS) ? rda_pkg::MAX_REGS : int'(v);
  endtask

  // Blocks of allocates and marks over a small value pool, mostly closed by a flush
  task automatic run_phase(input int words);
    logic [rda_pkg::VALUE_W-1:0] pool [8];
    int sent;
    int block_len;
    int k;
    int roll;
    logic [rda_pkg::REG_W-1:0] ri;
    sent = 0;
    while (sent < words) begin
      for (k = 0; k < 8; k++) pool[k] = rda_pkg::VALUE_W'($urandom);
      block_len = $urandom_range(3, 18);
      for (k = 0; k < block_len; k++) begin
        roll = $urandom_range(99);
        ri = ($urandom_range(4) != 0) ? rda_pkg::REG_W'($urandom_range(live - 1))
                                      : rda_pkg::REG_W'($urandom_range(7));
        if (roll < 60)
          send_word(rda_pkg::REQ_ALLOC, pool[$urandom_range(7)], 1'($urandom_range(1)),
                    ri);
        else if (roll < 70)
          send_word(rda_pkg::REQ_ALLOC, rda_pkg::VALUE_W'($urandom),
                    1'($urandom_range(1)), ri);
        else if (roll < 95)
          send_word(rda_pkg::REQ_MARK, rda_pkg::VALUE_W'($urandom),
                    1'($urandom_range(1)), ri);
        else
          send_word(REQ_UNUSED, rda_pkg::VALUE_W'($urandom), 1'($urandom_range(1)), ri);
      end
      if ($urandom_range(9) != 0)
        send_word(rda_pkg::REQ_FLUSH, rda_pkg::VALUE_W'($urandom), 1'($urandom_range(1)),
                  rda_pkg::REG_W'($urandom_range(7)));
      sent += block_len + 1;
    end
  endtask

  initial begin : stimulus
    logic [rda_pkg::CNT_W-1:0] counts [8];
    int phase;
    counts = '{4'd5, 4'd0, 4'd8, 4'd15, 4'd1, 4'd3, 4'd8, 4'd2};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty flush, hits, ignored marks, evictions, shrink then flush
    send_word(rda_pkg::REQ_FLUSH, 16'h0000, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_ALLOC, 16'h0000, 1'b1, 3'd0);
    send_word(rda_pkg::REQ_ALLOC, 16'hFFFF, 1'b1, 3'd7);
    send_word(rda_pkg::REQ_ALLOC, 16'h0000, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_MARK, 16'h0000, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_MARK, 16'hFFFF, 1'b1, 3'd7);
    send_word(rda_pkg::REQ_MARK, 16'h0000, 1'b0, 3'd3);
    send_word(REQ_UNUSED, 16'hFFFF, 1'b1, 3'd7);
    send_word(rda_pkg::REQ_ALLOC, 16'h1234, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_ALLOC, 16'h8000, 1'b1, 3'd0);
    send_word(rda_pkg::REQ_ALLOC, 16'h5555, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_ALLOC, 16'hAAAA, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_MARK, 16'h0000, 1'b0, 3'd1);
    send_word(rda_pkg::REQ_MARK, 16'h0000, 1'b0, 3'd2);
    send_word(rda_pkg::REQ_MARK, 16'h0000, 1'b0, 3'd3);
    send_word(rda_pkg::REQ_MARK, 16'h0000, 1'b0, 3'd4);
    send_word(rda_pkg::REQ_ALLOC, 16'h00FF, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_ALLOC, 16'h8000, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_MARK, 16'h0000, 1'b0, 3'd0);
    send_word(rda_pkg::REQ_ALLOC, 16'h7777, 1'b0, 3'd0);
    write_regs(4'd2);
    send_word(rda_pkg::REQ_FLUSH, 16'hFFFF, 1'b1, 3'd7);
    send_word(rda_pkg::REQ_ALLOC, 16'h1234, 1'b0, 3'd0);

    // Random phases across register counts and idle/stall patterns
    for (phase = 0; phase < 8; phase++) begin
      write_regs(counts[phase]);
      idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 1) ? 66 : 14) : 0;
      stall_pct <= (phase % 4 == 2) ? 66 : (phase % 4 == 3) ? 14 : 0;
      if (phase == 4) begin
        // Long result hold-off while words keep coming
        hold_off <= 1'b1;
        @(posedge clk);
        hold_off <= 1'b0;
      end
      run_phase(PHASE_WORDS);
    end

    drain();
    if (mismatch_count == 0 && owed_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
